// File: sv/dim_profile_relative_to_level_top_macros.svh
// assertion macros for the dimming profile level mapper checker
`ifndef DIM_PROFILE_RELATIVE_TO_LEVEL_TOP_MACROS_SVH
`define DIM_PROFILE_RELATIVE_TO_LEVEL_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DPLR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("dplr check failed");

// consequence in the same cycle
`define DPLR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dplr check failed");

// consequence in the next cycle
`define DPLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dplr check failed");

`endif

// File: sv/dplr_pkg.sv
// shared types, constants and curve table builder for the level mapper
package dplr_pkg;

  localparam int HALF_STEPS = 506;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] LEVEL_ZERO = 8'd0;
  localparam logic [7:0] LEVEL_TOP  = 8'd254;
  localparam logic [7:0] LEVEL_BAD  = 8'd255;

  localparam logic CURVE_LOG = 1'b0;
  localparam logic CURVE_LIN = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE = 2'd0,
    CFG_MIN   = 2'd1,
    CFG_MAX   = 2'd2
  } cfg_idx_t;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  typedef logic [63:0] std_tab_t [0:HALF_STEPS];

  // q2.62 product, truncated
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[125:62];
  endfunction

  function automatic logic [63:0] pow_q62(logic [63:0] base_in, logic [9:0] e_in);
    logic [63:0] r;
    logic [63:0] base;
    logic [9:0]  e;
    r    = Q62_ONE;
    base = base_in;
    e    = e_in;
    for (int i = 0; i < 10; i++) begin
      if (e[0]) r = mul_q62(r, base);
      base = mul_q62(base, base);
      e    = e >> 1;
    end
    return r;
  endfunction

  // half-step outputs of the standard curve, rounded to ofb fraction bits
  function automatic std_tab_t build_std(int ofb);
    std_tab_t    tab;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] v;
    logic [63:0] rnd;
    int          s;
    target = (Q62_ONE + 64'd500) / 64'd1000;
    lo     = 64'd0;
    hi     = Q62_ONE;
    for (int it = 0; it < 64; it++) begin
      if (hi - lo > 64'd1) begin
        m = lo + ((hi - lo) >> 1);
        if (pow_q62(m, 10'(HALF_STEPS)) <= target) lo = m;
        else hi = m;
      end
    end
    q   = lo;
    v   = Q62_ONE;
    s   = 62 - ofb;
    rnd = 64'd1 << (s - 1);
    for (int h = HALF_STEPS; h >= 0; h--) begin
      tab[h] = (v + rnd) >> s;
      v      = mul_q62(v, q);
    end
    return tab;
  endfunction

endpackage

// File: sv/dim_profile_relative_to_level_top.sv
// top level of the dimming profile level mapper: relative brightness to light level
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_relative (Q1.RELATIVE_FRAC_BITS)
//  out_     output     out_valid/out_stall  out_level (8 bits), out_status (1 bit)
//  cfg_     input      cfg_valid/cfg_ready  cfg_index (2 bits), cfg_data (8 bits)
//
// one transaction per cycle in while in_stall is low; a result passes through
// 12 register stages: rom read, multiply, round, 8 binary-search steps, output
// the standard curve is inverted by an 8-step search, one midpoint rom read a stage
// rst_n (synchronous) empties the pipeline and restores the profile registers
// stages advance independently, so bubbles close up behind a stalled result
// cfg_ready is always high; an unknown register index is dropped
module dim_profile_relative_to_level_top #(
  parameter int RELATIVE_FRAC_BITS = 16,
  parameter int OUTPUT_FRAC_BITS   = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [RELATIVE_FRAC_BITS:0]         in_relative,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_level,
  output logic                                out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dplr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);
  import dplr_pkg::*;

  localparam int RW = RELATIVE_FRAC_BITS + 1;   // relative input width
  localparam int OW = OUTPUT_FRAC_BITS + 1;     // output value width, holds 1.0
  localparam int PW = RW + OW;                  // interpolation product
  localparam int LP = OW + 8;                   // linear inverse product
  localparam int NQ = 8;                        // search steps over 256 midpoints
  localparam int NS = 3 + NQ;                   // stages before the output register

  localparam logic [RW-1:0] REL_ONE = RW'(1) << RELATIVE_FRAC_BITS;
  localparam logic [PW-1:0] REL_HALF = PW'(1) << (RELATIVE_FRAC_BITS - 1);
  localparam logic [LP-1:0] OUT_HALF = LP'(1) << (OUTPUT_FRAC_BITS - 1);
  localparam logic [7:0]    SEARCH_TOP = 8'h80;

  // curve roms, built at elaboration
  localparam std_tab_t STD_TAB = build_std(OUTPUT_FRAC_BITS);

  typedef logic [OW-1:0] mp_tab_t [0:255];
  typedef logic [OW-1:0] lvl_tab_t [0:511];

  // midpoints padded: entry 0 always passes, the top two never do
  function automatic mp_tab_t build_mp();
    mp_tab_t t;
    for (int k = 0; k < 256; k++) begin
      if (k == 0) t[k] = '0;
      else if (k <= 253) t[k] = OW'(STD_TAB[2 * k - 1]);
      else t[k] = '1;
    end
    return t;
  endfunction

  // level outputs indexed by {curve, level}
  function automatic lvl_tab_t build_lvl();
    lvl_tab_t t;
    for (int l = 0; l < 256; l++) begin
      if (l >= 1 && l <= 254) t[l] = OW'(STD_TAB[2 * (l - 1)]);
      else t[l] = '0;
      t[256 + l] = OW'(((64'(l) << OUTPUT_FRAC_BITS) + 64'd127) / 64'd254);
    end
    return t;
  endfunction

  localparam mp_tab_t  MP_TAB  = build_mp();
  localparam lvl_tab_t LVL_TAB = build_lvl();

  typedef struct packed {
    logic          bad;
    logic          single;
    logic          lin_mode;
    logic [7:0]    mn;
    logic [7:0]    mx;
    logic [RW-1:0] rel;
    logic [OW-1:0] lo;
    logic [PW-1:0] prod;
    logic [OW-1:0] o;
    logic [7:0]    lin_lvl;
    logic [7:0]    p;
    logic [7:0]    cand;
  } pl_t;

  // profile registers
  logic       curve_r;
  logic [7:0] min_level_r;
  logic [7:0] max_level_r;

  // pipeline
  logic [NS-1:0] v_r;
  pl_t           st_r   [NS];
  pl_t           st_nxt [NS];
  logic [NS:0]   ld;
  logic [OW-1:0] lo_rd_r;
  logic [OW-1:0] hi_rd_r;
  logic [OW-1:0] rd_r [NQ];
  logic [7:0]    pd   [NQ];

  logic [PW-1:0] rnd_sum;
  logic [LP-1:0] lin_prod;
  logic [LP-1:0] lin_sh;
  logic [8:0]    lin_raw;

  // output register
  logic       out_valid_r;
  logic [7:0] out_level_r;
  logic       out_status_r;
  logic [7:0] level_nxt;
  logic       status_nxt;
  logic [7:0] std_lvl;
  logic [7:0] cur_lvl;
  logic [7:0] clamp_lvl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_r     <= CURVE_LOG;
      min_level_r <= 8'd1;
      max_level_r <= LEVEL_TOP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CURVE: curve_r     <= cfg_data[0];
        CFG_MIN:   min_level_r <= cfg_data;
        CFG_MAX:   max_level_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // a stage loads when empty or when its content moves on
  always_comb begin
    ld[NS] = !out_valid_r || !out_stall;
    for (int s = NS - 1; s >= 0; s--) begin
      ld[s] = !v_r[s] || ld[s+1];
    end
  end

  assign in_stall = !ld[0];

  always_comb begin
    // accept: snapshot the profile and classify
    st_nxt[0]          = '0;
    st_nxt[0].bad      = (min_level_r == LEVEL_ZERO) || (max_level_r == LEVEL_BAD) ||
                         (min_level_r > max_level_r) || (in_relative > REL_ONE);
    st_nxt[0].single   = (min_level_r == max_level_r);
    st_nxt[0].lin_mode = curve_r;
    st_nxt[0].mn       = min_level_r;
    st_nxt[0].mx       = max_level_r;
    st_nxt[0].rel      = in_relative;

    // interpolation product
    st_nxt[1]      = st_r[0];
    st_nxt[1].lo   = lo_rd_r;
    st_nxt[1].prod = PW'(st_r[0].rel) * PW'(hi_rd_r - lo_rd_r);

    // rounded output value
    rnd_sum     = st_r[1].prod + REL_HALF;
    st_nxt[2]   = st_r[1];
    st_nxt[2].o = st_r[1].lo + OW'(rnd_sum >> RELATIVE_FRAC_BITS);

    // linear inverse and search entry
    lin_prod  = LP'(st_r[2].o) * LP'(254) + OUT_HALF;
    lin_sh    = lin_prod >> OUTPUT_FRAC_BITS;
    lin_raw   = lin_sh[8:0];
    st_nxt[3] = st_r[2];
    if (lin_raw == 9'd0) st_nxt[3].lin_lvl = 8'd1;
    else if (lin_raw > 9'(LEVEL_TOP)) st_nxt[3].lin_lvl = LEVEL_TOP;
    else st_nxt[3].lin_lvl = lin_raw[7:0];
    st_nxt[3].p    = 8'd0;
    st_nxt[3].cand = SEARCH_TOP;

    // one search bit per stage
    for (int j = 0; j < NQ; j++) begin
      pd[j] = (rd_r[j] <= st_r[3+j].o) ? st_r[3+j].cand : st_r[3+j].p;
    end
    for (int j = 0; j < NQ - 1; j++) begin
      st_nxt[4+j]      = st_r[3+j];
      st_nxt[4+j].p    = pd[j];
      st_nxt[4+j].cand = pd[j] | 8'(SEARCH_TOP >> (j + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (ld[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // payload and rom reads, no reset
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      lo_rd_r <= LVL_TAB[{curve_r, min_level_r}];
      hi_rd_r <= LVL_TAB[{curve_r, max_level_r}];
    end
    for (int s = 0; s < NS; s++) begin
      if (ld[s]) st_r[s] <= st_nxt[s];
    end
    for (int j = 0; j < NQ; j++) begin
      if (ld[3+j]) rd_r[j] <= MP_TAB[st_nxt[3+j].cand];
    end
  end

  // final selection, clamp and special cases
  always_comb begin
    std_lvl = pd[NQ-1] + 8'd1;
    cur_lvl = (st_r[NS-1].lin_mode == CURVE_LIN) ? st_r[NS-1].lin_lvl : std_lvl;
    if (cur_lvl < st_r[NS-1].mn) clamp_lvl = st_r[NS-1].mn;
    else if (cur_lvl > st_r[NS-1].mx) clamp_lvl = st_r[NS-1].mx;
    else clamp_lvl = cur_lvl;
    priority if (st_r[NS-1].bad) begin
      level_nxt  = LEVEL_ZERO;
      status_nxt = STATUS_INVALID;
    end else if (st_r[NS-1].single) begin
      level_nxt  = st_r[NS-1].mn;
      status_nxt = STATUS_OK;
    end else begin
      level_nxt  = clamp_lvl;
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld[NS]) begin
      out_valid_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NS]) begin
      out_level_r  <= level_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_level  = out_level_r;
  assign out_status = out_status_r;

endmodule

// File: sv/dplr_checker.sv
// port-level checker for the level mapper and its bind
`include "dim_profile_relative_to_level_top_macros.svh"

module dplr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_level,
  input logic       out_status
);
  import dplr_pkg::*;

  `DPLR_ASSERT_IMPL(a_invalid_level_zero, out_valid && (out_status == STATUS_INVALID), out_level == LEVEL_ZERO)
  `DPLR_ASSERT_IMPL(a_ok_level_range, out_valid && (out_status == STATUS_OK), (out_level != LEVEL_ZERO) && (out_level <= LEVEL_TOP))
  `DPLR_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall, out_valid && $stable(out_level) && $stable(out_status))

endmodule

bind dim_profile_relative_to_level_top dplr_checker u_dplr_checker (.*);

// File: tb/tb_dim_profile_relative_to_level_top.sv
// testbench for the dimming profile level mapper: directed and random profiles, scoreboard check
module tb_dim_profile_relative_to_level_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dplr_pkg::*;

  localparam int REL_FB = 16;
  localparam int OUT_FB = 24;
  localparam int ITEM_GOAL = 1100;
  // register index that the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] level;
    logic       status;
  } level_result_t;

  // dut ports, the inputs known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REL_FB:0]   in_relative = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_level;
  logic              out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  // profile copy kept in step with every accepted register write
  logic       prof_curve = CURVE_LOG;
  logic [7:0] prof_min = 8'd1;
  logic [7:0] prof_max = LEVEL_TOP;

  // standard curve outputs per half-step, q1.24
  logic [63:0] curve_pts [0:HALF_STEPS];

  logic [REL_FB:0] stim_q [$];      // brightness values not yet accepted
  level_result_t   result_q [$];    // levels predicted, waiting on the output
  bit in_held = 1'b0;               // a transaction is on the input port
  bit steady = 1'b0;                // no idling on either side while set

  int fail_count = 0;
  int checked_count = 0;
  int invalid_count = 0;
  int profile_count = 1;

  dim_profile_relative_to_level_top #(
    .RELATIVE_FRAC_BITS(REL_FB),
    .OUTPUT_FRAC_BITS  (OUT_FB)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_relative(in_relative),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_level  (out_level),
    .out_status (out_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // q2.62 product, low bits dropped
  function automatic logic [63:0] q62_mul(logic [63:0] x, logic [63:0] y);
    logic [127:0] wide;
    wide = 128'(x) * 128'(y);
    return wide[125:62];
  endfunction

  // right-to-left square and multiply, same truncation order as the curve definition
  function automatic logic [63:0] q62_pow(logic [63:0] x, int unsigned ex);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 << 62;
    sq  = x;
    for (int i = 0; i < 10; i++) begin
      if (ex[i]) acc = q62_mul(acc, sq);
      sq = q62_mul(sq, sq);
    end
    return acc;
  endfunction

  // output value of one level on the active curve
  function automatic logic [63:0] level_to_output(logic [7:0] lvl);
    if (prof_curve == CURVE_LIN) return ((64'(lvl) << OUT_FB) + 64'd127) / 64'd254;
    return curve_pts[2 * (int'(lvl) - 1)];
  endfunction

  // expected level and status for one brightness value under the current profile
  function automatic level_result_t map_relative(logic [REL_FB:0] rel);
    level_result_t res;
    logic [63:0] lo_out;
    logic [63:0] hi_out;
    logic [63:0] mix;
    logic [63:0] lvl;
    res.level  = LEVEL_ZERO;
    res.status = STATUS_INVALID;
    if (prof_min == LEVEL_ZERO || prof_max == LEVEL_BAD || prof_min > prof_max ||
        64'(rel) > (64'd1 << REL_FB)) return res;
    res.status = STATUS_OK;
    if (prof_min == prof_max) begin
      res.level = prof_min;
      return res;
    end
    lo_out = level_to_output(prof_min);
    hi_out = level_to_output(prof_max);
    // linear blend in output space, rounded half up
    mix = lo_out + ((64'(rel) * (hi_out - lo_out) + (64'd1 << (REL_FB - 1))) >> REL_FB);
    if (prof_curve == CURVE_LIN) begin
      lvl = (mix * 64'd254 + (64'd1 << (OUT_FB - 1))) >> OUT_FB;
      if (lvl < 64'd1) lvl = 64'd1;
      if (lvl > 64'(LEVEL_TOP)) lvl = 64'(LEVEL_TOP);
    end else begin
      // count geometric midpoints at or below the blended output
      lvl = 64'd1;
      for (int k = 1; k <= 253; k++) begin
        if (mix >= curve_pts[2 * k - 1]) lvl++;
      end
    end
    if (lvl < 64'(prof_min)) lvl = 64'(prof_min);
    if (lvl > 64'(prof_max)) lvl = 64'(prof_max);
    res.level = lvl[7:0];
    return res;
  endfunction

  // input driver: a transaction on the port stays until it is taken
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      result_q.push_back(map_relative(in_relative));
      void'(stim_q.pop_front());
      in_held = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!in_held) begin
      if (rst_n && stim_q.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
        in_valid    <= 1'b1;
        in_relative <= stim_q[0];
        in_held = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, about a third of the cycles outside the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 36);
  end

  // output monitor: every result against the oldest prediction
  always @(posedge clk) begin
    level_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: level %0d status %0d", out_level, out_status);
        fail_count++;
      end else begin
        exp_res = result_q.pop_front();
        checked_count++;
        if (exp_res.status == STATUS_INVALID) invalid_count++;
        if (out_level !== exp_res.level) begin
          $error("level mismatch: expected %0d, actual %0d", exp_res.level, out_level);
          fail_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status mismatch: expected %0d, actual %0d", exp_res.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // block is drained: nothing queued, on the port, or in flight
  task automatic wait_idle();
    while (stim_q.size() != 0 || result_q.size() != 0 || in_held) @(posedge clk);
  endtask

  // one register write transaction; the profile copy follows the accepted write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CURVE: prof_curve = data[0];
      CFG_MIN:   prof_min   = data;
      CFG_MAX:   prof_max   = data;
      default: ;  // undecoded index, dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // reprogram the whole profile once the pipeline is empty
  task automatic set_profile(logic curve, logic [7:0] mn, logic [7:0] mx);
    wait_idle();
    // upper data bits of the curve register are don't-care
    write_reg(CFG_CURVE, {7'($urandom), curve});
    write_reg(CFG_MIN, mn);
    write_reg(CFG_MAX, mx);
    profile_count++;
  endtask

  initial begin
    logic [63:0] lo_q;
    logic [63:0] hi_q;
    logic [63:0] mid_q;
    logic [63:0] step_q;
    logic [63:0] v;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        curve;
    logic [REL_FB:0] rel;
    int issued;
    int n;
    int phase;

    // step ratio 10^(-3/506): largest q62 value whose 506th power stays at or below 1/1000
    lo_q = 64'd0;
    hi_q = 64'd1 << 62;
    while (hi_q - lo_q > 64'd1) begin
      mid_q = lo_q + (hi_q - lo_q) / 2;
      if (q62_pow(mid_q, HALF_STEPS) <= ((64'd1 << 62) + 64'd500) / 64'd1000) lo_q = mid_q;
      else hi_q = mid_q;
    end
    step_q = lo_q;
    // walk down from 1.0, rounding each point to 24 fraction bits
    v = 64'd1 << 62;
    for (int h = HALF_STEPS; h >= 0; h--) begin
      curve_pts[h] = (v + (64'd1 << (62 - OUT_FB - 1))) >> (62 - OUT_FB);
      v = q62_mul(v, step_q);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset profile: standard curve over the full range, field extremes and out-of-range input
    stim_q = '{17'd0, 17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd65537,
               17'd131071, 17'h0AAAA, 17'h15555};
    // linear curve over the full range
    set_profile(CURVE_LIN, 8'd1, LEVEL_TOP);
    stim_q = '{17'd0, 17'd1, 17'd32768, 17'd65536};
    // single-level profiles at both ends
    set_profile(CURVE_LOG, LEVEL_TOP, LEVEL_TOP);
    stim_q.push_back(17'd12345);
    set_profile(CURVE_LIN, 8'd1, 8'd1);
    stim_q.push_back(17'd65536);
    // invalid profiles: zero minimum, maximum of 255, minimum above maximum
    set_profile(CURVE_LOG, LEVEL_ZERO, LEVEL_TOP);
    stim_q.push_back(17'd32768);
    set_profile(CURVE_LIN, 8'd1, LEVEL_BAD);
    stim_q.push_back(17'd32768);
    set_profile(CURVE_LOG, 8'd200, 8'd100);
    stim_q.push_back(17'd32768);
    // write to an undecoded index must leave the profile alone
    set_profile(CURVE_LOG, 8'd1, LEVEL_TOP);
    write_reg(CFG_UNUSED, 8'hFF);
    stim_q.push_back(17'd65536);

    // random phases, each with a fresh profile; the third runs with no idling at all
    issued = 0;
    phase = 0;
    while (issued < ITEM_GOAL) begin
      curve = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: begin
          a = 8'd1;
          b = LEVEL_TOP;
        end
        1: begin
          // anything goes, usually an invalid profile
          a = 8'($urandom_range(255));
          b = 8'($urandom_range(255));
        end
        2: begin
          a = 8'($urandom_range(1, 254));
          b = a;
        end
        3: begin
          a = 8'($urandom_range(1, 254));
          b = LEVEL_TOP;
        end
        default: begin
          a = 8'($urandom_range(1, 254));
          b = 8'($urandom_range(1, 254));
          if (a > b) {a, b} = {b, a};
        end
      endcase
      set_profile(curve, a, b);
      steady = (phase == 2);
      n = steady ? 200 : $urandom_range(30, 90);
      repeat (n) begin
        case ($urandom_range(19))
          0:       rel = 17'd0;
          1:       rel = 17'd65536;
          2, 3:    rel = 17'($urandom_range(131071));  // half of these out of range
          default: rel = 17'($urandom_range(65536));
        endcase
        stim_q.push_back(rel);
      end
      issued += n;
      phase++;
    end

    wait_idle();
    steady = 1'b0;
    // let any stray result surface past the pipeline depth
    repeat (30) @(posedge clk);
    $display("checked %0d levels across %0d profile settings, %0d of them flagged invalid",
             checked_count, profile_count, invalid_count);
    if (fail_count == 0) begin
      $display("tb_dim_profile_relative_to_level_top passed");
    end else begin
      $display("tb_dim_profile_relative_to_level_top failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_dim_profile_relative_to_level_top failed");
    $finish;
  end

endmodule

// File: dim_profile_relative_to_level_top.f
+incdir+sv
sv/dplr_pkg.sv
sv/dim_profile_relative_to_level_top.sv
sv/dplr_checker.sv
tb/tb_dim_profile_relative_to_level_top.sv
